// ===== rtl/peer_rate_limiter_with_alarm_defines.svh =====
// Assertion macros for the checker file of the peer rate limiter.
`ifndef PEER_RATE_LIMITER_WITH_ALARM_DEFINES_SVH
`define PEER_RATE_LIMITER_WITH_ALARM_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define PRL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define PRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/prl_pkg.sv =====
// Package: constants, codes and control types of the peer rate limiter.
`timescale 1ns / 1ps
`default_nettype none

package prl_pkg;

	localparam int PEERS_DEF       = 4;
	localparam int SLOTS_DEF       = 4;
	localparam int COUNT_WIDTH_DEF = 24;

	localparam int LIMIT_W      = 16;
	localparam int LIMIT_REGS   = 4;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int MASK_W       = 4;
	localparam int PEER_FIELD_W = 4;
	localparam int OUT_CNT_W    = 24;
	localparam int SLOT_FIELD_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_USED_MASK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_EN  = 3'd5;

	localparam logic MODE_REQ  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic KIND_VERDICT  = 1'b0;
	localparam logic KIND_SNAPSHOT = 1'b1;

	localparam logic [1:0] VERDICT_PASS    = 2'd0;
	localparam logic [1:0] VERDICT_DROP    = 2'd1;
	localparam logic [1:0] VERDICT_INVALID = 2'd2;

	localparam logic [1:0] ALARM_NONE    = 2'd0;
	localparam logic [1:0] ALARM_RAISED  = 2'd1;
	localparam logic [1:0] ALARM_CLEARED = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic req;        // evaluate request beat and load verdict
		logic snap;       // load snapshot of the indexed peer, clear its counters
		logic snap_last;  // final snapshot of the tick: advance slot
	} prl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/prl_ctrl.sv =====
// Controller: input/output handshake, tick sequencing and output valid.
`timescale 1ns / 1ps
`default_nettype none

module prl_ctrl #(
	parameter int PEERS = prl_pkg::PEERS_DEF,
	parameter int PEER_W = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              mode,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output prl_pkg::prl_cmd_t      cmd,
	output logic [PEER_W-1:0]      tick_idx
);
	import prl_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_TICK
	} state_t;

	state_t              state_q;
	logic [PEER_W-1:0]   tick_idx_q;
	logic                out_valid_q;
	logic                out_free;
	logic                accept;

	// output register can take a beat when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;

	assign cmd.req       = accept && (mode == MODE_REQ);
	assign cmd.snap      = (state_q == S_TICK) && out_free;
	assign cmd.snap_last = (tick_idx_q == PEER_W'(PEERS - 1));

	assign out_valid = out_valid_q;
	assign tick_idx  = tick_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tick_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.req || cmd.snap) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (mode == MODE_TICK)) begin
						state_q    <= S_TICK;
						tick_idx_q <= '0;
					end
				end
				S_TICK: begin
					if (cmd.snap) begin
						if (cmd.snap_last) begin
							state_q <= S_IDLE;
						end else begin
							tick_idx_q <= PEER_W'(tick_idx_q + 1'b1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/prl_dp.sv =====
// Datapath: configuration registers, per-peer counters and flags, output register.
`timescale 1ns / 1ps
`default_nettype none

module prl_dp #(
	parameter int PEERS = prl_pkg::PEERS_DEF,
	parameter int SLOTS = prl_pkg::SLOTS_DEF,
	parameter int COUNT_WIDTH = prl_pkg::COUNT_WIDTH_DEF,
	parameter int PEER_W = 2
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [prl_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire logic [prl_pkg::CFG_DATA_W-1:0]     wr_data,
	input  wire prl_pkg::prl_cmd_t                  cmd,
	input  wire logic [PEER_W-1:0]                  tick_idx,
	input  wire logic [prl_pkg::PEER_FIELD_W-1:0]   peer_index,
	output logic                                    kind,
	output logic [1:0]                              verdict,
	output logic [1:0]                              alarm_change,
	output logic [prl_pkg::PEER_FIELD_W-1:0]        peer,
	output logic [prl_pkg::OUT_CNT_W-1:0]           accepted_count,
	output logic [prl_pkg::OUT_CNT_W-1:0]           dropped_count,
	output logic [prl_pkg::SLOT_FIELD_W-1:0]        window_slot,
	output logic                                    last_of_run
);
	import prl_pkg::*;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CMP_W  = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [LIMIT_W-1:0]      limit_q [LIMIT_REGS];
	logic [MASK_W-1:0]       used_mask_q;
	logic                    alarm_en_q;

	logic [COUNT_WIDTH-1:0]  acc_q [PEERS];
	logic [COUNT_WIDTH-1:0]  drp_q [PEERS];
	logic [PEERS-1:0]        flag_q;
	logic [SLOT_W-1:0]       slot_q;

	logic                    kind_q;
	logic [1:0]              verdict_q;
	logic [1:0]              change_q;
	logic [PEER_FIELD_W-1:0] peer_q;
	logic [OUT_CNT_W-1:0]    acc_out_q;
	logic [OUT_CNT_W-1:0]    drp_out_q;
	logic [SLOT_FIELD_W-1:0] slot_out_q;
	logic                    last_q;

	logic [PEER_W-1:0]       rd_idx;
	logic [COUNT_WIDTH-1:0]  acc_rd;
	logic [COUNT_WIDTH-1:0]  drp_rd;
	logic                    flag_rd;
	logic [LIMIT_W-1:0]      lim;
	logic                    peer_ok;
	logic                    over;
	logic                    snap_used;
	logic [1:0]              req_verdict;
	logic [1:0]              req_change;

	// one counter port, shared by requests and tick snapshots
	assign rd_idx  = cmd.req ? peer_index[PEER_W-1:0] : tick_idx;
	assign acc_rd  = acc_q[rd_idx];
	assign drp_rd  = drp_q[rd_idx];
	assign flag_rd = flag_q[rd_idx];

	assign lim     = limit_q[peer_index[1:0]];
	assign peer_ok = (peer_index < PEER_FIELD_W'(PEERS));
	assign over    = (lim != '0) && (CMP_W'(acc_rd) >= CMP_W'(lim));

	assign snap_used = used_mask_q[2'(tick_idx)];

	always_comb begin
		req_change = ALARM_NONE;
		if (!peer_ok) begin
			req_verdict = VERDICT_INVALID;
		end else if (over) begin
			req_verdict = VERDICT_DROP;
			if (!flag_rd && alarm_en_q) begin
				req_change = ALARM_RAISED;
			end
		end else begin
			req_verdict = VERDICT_PASS;
			if (flag_rd && alarm_en_q) begin
				req_change = ALARM_CLEARED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIMIT_REGS; i++) begin
				limit_q[i] <= '0;
			end
			used_mask_q <= '0;
			alarm_en_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LIMIT0:    limit_q[0] <= wr_data[LIMIT_W-1:0];
				REG_LIMIT1:    limit_q[1] <= wr_data[LIMIT_W-1:0];
				REG_LIMIT2:    limit_q[2] <= wr_data[LIMIT_W-1:0];
				REG_LIMIT3:    limit_q[3] <= wr_data[LIMIT_W-1:0];
				REG_USED_MASK: used_mask_q <= wr_data[MASK_W-1:0];
				REG_ALARM_EN:  alarm_en_q <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PEERS; i++) begin
				acc_q[i] <= '0;
				drp_q[i] <= '0;
			end
			flag_q <= '0;
			slot_q <= '0;
		end else begin
			if (cmd.req && peer_ok) begin
				if (over) begin
					drp_q[rd_idx]  <= (drp_rd == CNT_MAX) ? drp_rd
						: COUNT_WIDTH'(drp_rd + 1'b1);
					flag_q[rd_idx] <= 1'b1;
				end else begin
					acc_q[rd_idx]  <= (acc_rd == CNT_MAX) ? acc_rd
						: COUNT_WIDTH'(acc_rd + 1'b1);
					flag_q[rd_idx] <= 1'b0;
				end
			end
			if (cmd.snap) begin
				acc_q[rd_idx] <= '0;
				drp_q[rd_idx] <= '0;
				if (cmd.snap_last) begin
					slot_q <= (slot_q == SLOT_W'(SLOTS - 1)) ? '0
						: SLOT_W'(slot_q + 1'b1);
				end
			end
		end
	end

	// output register: payload only, valid lives in the controller
	always_ff @(posedge clk) begin
		if (cmd.req) begin
			kind_q     <= KIND_VERDICT;
			verdict_q  <= req_verdict;
			change_q   <= req_change;
			peer_q     <= peer_index;
			acc_out_q  <= '0;
			drp_out_q  <= '0;
			slot_out_q <= SLOT_FIELD_W'(slot_q);
			last_q     <= 1'b1;
		end else if (cmd.snap) begin
			kind_q     <= KIND_SNAPSHOT;
			verdict_q  <= VERDICT_PASS;
			change_q   <= ALARM_NONE;
			peer_q     <= PEER_FIELD_W'(tick_idx);
			acc_out_q  <= snap_used ? OUT_CNT_W'(acc_rd) : '0;
			drp_out_q  <= snap_used ? OUT_CNT_W'(drp_rd) : '0;
			slot_out_q <= SLOT_FIELD_W'(slot_q);
			last_q     <= cmd.snap_last;
		end
	end

	assign kind           = kind_q;
	assign verdict        = verdict_q;
	assign alarm_change   = change_q;
	assign peer           = peer_q;
	assign accepted_count = acc_out_q;
	assign dropped_count  = drp_out_q;
	assign window_slot    = slot_out_q;
	assign last_of_run    = last_q;

endmodule

`default_nettype wire

// ===== rtl/peer_rate_limiter_with_alarm.sv =====
// Per-peer fixed-window rate limiter with overload alarm reporting: top level.
//
// A request beat (mode 0) is judged in the cycle it is accepted: one read-modify-write
// of the peer's counters, and the verdict lands in the output register, so requests
// flow at one per cycle while the result side keeps up. A tick beat (mode 1) is
// accepted, then yields one snapshot per peer, each passing through
// the single output register and the shared counter port; input stalls meanwhile.
// Counters, flags and slot number are cleared by reset directly; there is no
// clearing pass. Write configuration only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module peer_rate_limiter_with_alarm #(
	parameter int PEERS = prl_pkg::PEERS_DEF,
	parameter int SLOTS = prl_pkg::SLOTS_DEF,
	parameter int COUNT_WIDTH = prl_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [prl_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire logic [prl_pkg::CFG_DATA_W-1:0]     wr_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               mode,
	input  wire logic [prl_pkg::PEER_FIELD_W-1:0]   peer_index,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    kind,
	output logic [1:0]                              verdict,
	output logic [1:0]                              alarm_change,
	output logic [prl_pkg::PEER_FIELD_W-1:0]        peer,
	output logic [prl_pkg::OUT_CNT_W-1:0]           accepted_count,
	output logic [prl_pkg::OUT_CNT_W-1:0]           dropped_count,
	output logic [prl_pkg::SLOT_FIELD_W-1:0]        window_slot,
	output logic                                    last_of_run
);
	import prl_pkg::*;

	localparam int PEER_W = (PEERS > 1) ? $clog2(PEERS) : 1;

	prl_cmd_t          cmd;
	logic [PEER_W-1:0] tick_idx;

	prl_ctrl #(
		.PEERS (PEERS),
		.PEER_W(PEER_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.tick_idx (tick_idx)
	);

	prl_dp #(
		.PEERS      (PEERS),
		.SLOTS      (SLOTS),
		.COUNT_WIDTH(COUNT_WIDTH),
		.PEER_W     (PEER_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.cmd           (cmd),
		.tick_idx      (tick_idx),
		.peer_index    (peer_index),
		.kind          (kind),
		.verdict       (verdict),
		.alarm_change  (alarm_change),
		.peer          (peer),
		.accepted_count(accepted_count),
		.dropped_count (dropped_count),
		.window_slot   (window_slot),
		.last_of_run   (last_of_run)
	);

endmodule

`default_nettype wire

// ===== rtl/prl_checker.sv =====
// Port-level checker for the peer rate limiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "peer_rate_limiter_with_alarm_defines.svh"

module prl_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic                               mode,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic                               kind,
	input wire logic [1:0]                         verdict,
	input wire logic [1:0]                         alarm_change,
	input wire logic [prl_pkg::PEER_FIELD_W-1:0]   peer,
	input wire logic [prl_pkg::OUT_CNT_W-1:0]      accepted_count,
	input wire logic [prl_pkg::OUT_CNT_W-1:0]      dropped_count,
	input wire logic [prl_pkg::SLOT_FIELD_W-1:0]   window_slot,
	input wire logic                               last_of_run
);
	import prl_pkg::*;

	logic in_beat;
	assign in_beat = in_valid && !in_stall;

	`PRL_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(kind) && $stable(peer) && $stable(verdict)
		&& $stable(alarm_change) && $stable(accepted_count) && $stable(dropped_count)
		&& $stable(window_slot) && $stable(last_of_run),
		"stalled output beat changed")

	`PRL_ASSERT_NOW(a_no_take_when_blocked, out_valid && out_stall, in_stall,
		"input taken while output register blocked")

	`PRL_ASSERT_NEXT(a_tick_busy, in_beat && (mode == MODE_TICK), in_stall,
		"input not held off during tick snapshots")

	`PRL_ASSERT_NEXT(a_req_verdict, in_beat && (mode == MODE_REQ),
		out_valid && (kind == KIND_VERDICT) && last_of_run,
		"request beat did not yield a single verdict")

	`PRL_ASSERT_NOW(a_snap_clean, out_valid && (kind == KIND_SNAPSHOT),
		(verdict == VERDICT_PASS) && (alarm_change == ALARM_NONE),
		"snapshot carries verdict or alarm")

endmodule

bind peer_rate_limiter_with_alarm prl_checker u_prl_checker (.*);

`default_nettype wire
